### hw/rtl/bqf_pkg.sv
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared widths and constants of the billboard quad flatten pipeline.
// ----------------------------------------------------------------------------
package bqf_pkg;

  localparam int COORD_BITS_DEF = 32;
  // normalized cross magnitude, top bit at 2^30
  localparam int MAN_BITS       = 31;
  localparam int SUM_BITS       = 64;
  localparam int LEN_BITS       = 32;
  localparam int SQRT_STEPS     = 32;
  localparam int QUO_BITS       = 31;
  // normal components in Q2.30
  localparam int NRM_BITS       = 32;
  localparam int AXIS_BITS      = 33;
  localparam int ONE_SHIFT      = 30;

endpackage

### hw/rtl/bqf_in_if.sv
// ----------------------------------------------------------------------------
// bqf_in_if
// Quad request channel: four corner positions, valid and ready.
// ----------------------------------------------------------------------------
interface bqf_in_if #(
  parameter int COORD_BITS = bqf_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_x;
  logic signed [COORD_BITS-1:0] a_y;
  logic signed [COORD_BITS-1:0] a_z;
  logic signed [COORD_BITS-1:0] b_x;
  logic signed [COORD_BITS-1:0] b_y;
  logic signed [COORD_BITS-1:0] b_z;
  logic signed [COORD_BITS-1:0] c_x;
  logic signed [COORD_BITS-1:0] c_y;
  logic signed [COORD_BITS-1:0] c_z;
  logic signed [COORD_BITS-1:0] d_x;
  logic signed [COORD_BITS-1:0] d_y;
  logic signed [COORD_BITS-1:0] d_z;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z,
    output ready
  );
endinterface

### hw/rtl/bqf_out_if.sv
// ----------------------------------------------------------------------------
// bqf_out_if
// Result channel: pivot, per-corner billboard offsets and degenerate flag.
// ----------------------------------------------------------------------------
interface bqf_out_if #(
  parameter int COORD_BITS = bqf_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pivot_x;
  logic signed [COORD_BITS-1:0] pivot_y;
  logic signed [COORD_BITS-1:0] pivot_z;
  logic signed [COORD_BITS-1:0] a_u;
  logic signed [COORD_BITS-1:0] a_v;
  logic signed [COORD_BITS-1:0] b_u;
  logic signed [COORD_BITS-1:0] b_v;
  logic signed [COORD_BITS-1:0] c_u;
  logic signed [COORD_BITS-1:0] c_v;
  logic signed [COORD_BITS-1:0] d_u;
  logic signed [COORD_BITS-1:0] d_v;
  logic                         degenerate;

  modport source (
    output valid, pivot_x, pivot_y, pivot_z, a_u, a_v, b_u, b_v, c_u, c_v, d_u, d_v,
           degenerate,
    input  ready
  );
  modport sink (
    input  valid, pivot_x, pivot_y, pivot_z, a_u, a_v, b_u, b_v, c_u, c_v, d_u, d_v,
           degenerate,
    output ready
  );
endinterface

### hw/rtl/billboard_quad_flatten_core.sv
// ----------------------------------------------------------------------------
// billboard_quad_flatten_core
// Flattens a quad into a pivot and four 2D billboard offsets.
// ----------------------------------------------------------------------------
// Usage:
//   quad carries one request per quad: corners a, b, c (one triangle in
//   winding order) and the fourth corner d, signed fixed point.
//   result returns the pivot (mean of the corners), the u/v offset of each
//   corner on the billboard plane, and degenerate when the face normal has
//   zero length (offsets are then zero).
//   Throughput: one request per cycle, sustained while result.ready is high.
//   Pipeline from the accepting edge to result.valid: 7 stages of
//   cross product and normalizing shift, 32 square root stages (one root bit
//   each), 31 divider stages (one quotient bit each), 4 projection stages
//   and the output register.
//   Reset clears every stage valid bit and the output side; nothing is in
//   flight afterwards.
//   When the receiver stalls, the output register and a one-entry skid
//   stage hold results; the pipeline freezes only once the skid is full,
//   and quad.ready drops in that same cycle.
// ----------------------------------------------------------------------------
module billboard_quad_flatten_core #(
  parameter int COORD_BITS = bqf_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bqf_in_if.sink     quad,
  bqf_out_if.source  result
);

  localparam int EW      = COORD_BITS + 1;
  localparam int MB      = bqf_pkg::MAN_BITS;
  localparam int DV_SIDE = 12 * EW + 3 * COORD_BITS + 1;
  localparam int SQ_SIDE = DV_SIDE + 3 + 3 * MB;
  localparam int RES_W   = 11 * COORD_BITS + 1;

  logic en;

  logic [3:0][2:0][COORD_BITS-1:0]    p_in;
  logic                               fr_valid;
  logic [3:0][2:0][EW-1:0]            fr_d;
  logic [2:0][COORD_BITS-1:0]         fr_piv;
  logic [2:0]                         fr_neg;
  logic                               fr_degen;
  logic [2:0][MB-1:0]                 fr_m;
  logic [bqf_pkg::SUM_BITS-1:0]       fr_sum;

  logic                               sq_valid;
  logic [bqf_pkg::LEN_BITS-1:0]       sq_len;
  logic [SQ_SIDE-1:0]                 sq_side;
  logic [3:0][2:0][EW-1:0]            sq_d;
  logic [2:0][COORD_BITS-1:0]         sq_piv;
  logic [2:0]                         sq_neg;
  logic                               sq_degen;
  logic [2:0][MB-1:0]                 sq_m;

  logic                               dv_valid;
  logic [2:0][bqf_pkg::NRM_BITS-1:0]  dv_n;
  logic [DV_SIDE-1:0]                 dv_side;
  logic [3:0][2:0][EW-1:0]            dv_d;
  logic [2:0][COORD_BITS-1:0]         dv_piv;
  logic                               dv_degen;

  logic                               bk_valid;
  logic [2:0][COORD_BITS-1:0]         bk_piv;
  logic [3:0][COORD_BITS-1:0]         bk_u, bk_v;
  logic                               bk_degen;

  logic                               push;
  logic [RES_W-1:0]                   res_push;
  logic [RES_W-1:0]                   out_r, skid_r;
  logic                               out_v, skid_v;
  logic [2:0][COORD_BITS-1:0]         o_piv;
  logic [3:0][COORD_BITS-1:0]         o_u, o_v;
  logic                               o_degen;

  assign en         = !skid_v;
  assign quad.ready = en;

  assign p_in[0][0] = quad.a_x;
  assign p_in[0][1] = quad.a_y;
  assign p_in[0][2] = quad.a_z;
  assign p_in[1][0] = quad.b_x;
  assign p_in[1][1] = quad.b_y;
  assign p_in[1][2] = quad.b_z;
  assign p_in[2][0] = quad.c_x;
  assign p_in[2][1] = quad.c_y;
  assign p_in[2][2] = quad.c_z;
  assign p_in[3][0] = quad.d_x;
  assign p_in[3][1] = quad.d_y;
  assign p_in[3][2] = quad.d_z;

  bqf_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (quad.valid),
    .p_in      (p_in),
    .out_valid (fr_valid),
    .d_out     (fr_d),
    .piv_out   (fr_piv),
    .neg_out   (fr_neg),
    .degen_out (fr_degen),
    .m_out     (fr_m),
    .sum_out   (fr_sum)
  );

  bqf_sqrt #(.SW(SQ_SIDE)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .x         (fr_sum),
    .side      ({fr_m, fr_neg, fr_degen, fr_d, fr_piv}),
    .out_valid (sq_valid),
    .len       (sq_len),
    .side_out  (sq_side)
  );

  assign {sq_m, sq_neg, sq_degen, sq_d, sq_piv} = sq_side;

  bqf_div #(.SW(DV_SIDE)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .m         (sq_m),
    .len       (sq_len),
    .neg       (sq_neg),
    .side      ({sq_degen, sq_d, sq_piv}),
    .out_valid (dv_valid),
    .n         (dv_n),
    .side_out  (dv_side)
  );

  assign {dv_degen, dv_d, dv_piv} = dv_side;

  bqf_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv_valid),
    .n         (dv_n),
    .d         (dv_d),
    .piv       (dv_piv),
    .degen     (dv_degen),
    .out_valid (bk_valid),
    .piv_out   (bk_piv),
    .u_out     (bk_u),
    .v_out     (bk_v),
    .degen_out (bk_degen)
  );

  // output register with a one-entry skid behind it
  assign push     = en && bk_valid;
  assign res_push = {bk_piv, bk_u, bk_v, bk_degen};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (result.ready || !out_v) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v  <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (result.ready || !out_v) begin
      out_r <= skid_v ? skid_r : res_push;
    end else if (push) begin
      skid_r <= res_push;
    end
  end

  assign {o_piv, o_u, o_v, o_degen} = out_r;

  assign result.valid      = out_v;
  assign result.pivot_x    = o_piv[0];
  assign result.pivot_y    = o_piv[1];
  assign result.pivot_z    = o_piv[2];
  assign result.a_u        = o_u[0];
  assign result.a_v        = o_v[0];
  assign result.b_u        = o_u[1];
  assign result.b_v        = o_v[1];
  assign result.c_u        = o_u[2];
  assign result.c_v        = o_v[2];
  assign result.d_u        = o_u[3];
  assign result.d_v        = o_v[3];
  assign result.degenerate = o_degen;

endmodule

### hw/rtl/bqf_front.sv
// ----------------------------------------------------------------------------
// bqf_front
// Pivot, corner deltas, exact cross product, common normalizing shift and
// sum of squares. Seven register stages.
// ----------------------------------------------------------------------------
module bqf_front #(
  parameter int COORD_BITS = bqf_pkg::COORD_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              en,
  input  logic                                              in_valid,
  input  logic [3:0][2:0][COORD_BITS-1:0]                   p_in,
  output logic                                              out_valid,
  output logic [3:0][2:0][COORD_BITS:0]                     d_out,
  output logic [2:0][COORD_BITS-1:0]                        piv_out,
  output logic [2:0]                                        neg_out,
  output logic                                              degen_out,
  output logic [2:0][bqf_pkg::MAN_BITS-1:0]                 m_out,
  output logic [bqf_pkg::SUM_BITS-1:0]                      sum_out
);

  localparam int EW  = COORD_BITS + 1;
  localparam int MW  = 2 * COORD_BITS + 2;
  localparam int KW  = MW + 1;
  localparam int BLW = $clog2(MW + 1);
  localparam int MB  = bqf_pkg::MAN_BITS;

  logic [7:1] v;

  // stage 1
  logic [3:0][2:0][COORD_BITS-1:0] p1;
  logic [2:0][EW-1:0]              e1_1, e2_1;
  logic [2:0][COORD_BITS-1:0]      piv1;
  logic signed [COORD_BITS+1:0]    psum [3];
  // stage 2
  logic [5:0][MW-1:0]              pr2;
  logic [3:0][2:0][EW-1:0]         d2, d3, d4, d5, d6, d7;
  logic [2:0][COORD_BITS-1:0]      piv2, piv3, piv4, piv5, piv6, piv7;
  // stage 3
  logic signed [KW-1:0]            k3 [3];
  logic [KW-1:0]                   nk3 [3];
  logic [2:0][MW-1:0]              mag3, mag4;
  logic [2:0]                      neg3, neg4, neg5, neg6, neg7;
  // stage 4
  logic [MW-1:0]                   orv;
  logic [BLW-1:0]                  blen, blen4;
  logic                            dg4, dg5, dg6, dg7;
  // stage 5..7
  logic [MW+MB-1:0]                shv [3];
  logic [2:0][MB-1:0]              m5, m6, m7;
  logic [2:0][2*MB-1:0]            sq6;
  logic [bqf_pkg::SUM_BITS-1:0]    sum7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:1], in_valid};
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      psum[j] = $signed({{2{p_in[0][j][COORD_BITS-1]}}, p_in[0][j]})
              + $signed({{2{p_in[1][j][COORD_BITS-1]}}, p_in[1][j]})
              + $signed({{2{p_in[2][j][COORD_BITS-1]}}, p_in[2][j]})
              + $signed({{2{p_in[3][j][COORD_BITS-1]}}, p_in[3][j]});
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      k3[j] = $signed({pr2[2*j][MW-1], pr2[2*j]})
            - $signed({pr2[2*j+1][MW-1], pr2[2*j+1]});
      nk3[j] = -k3[j];
    end
  end

  // bit length of the largest magnitude
  always_comb begin
    orv  = mag3[0] | mag3[1] | mag3[2];
    blen = '0;
    for (int b = 0; b < MW; b++) begin
      if (orv[b]) blen = BLW'(b + 1);
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      shv[j] = {mag4[j], {MB{1'b0}}} >> blen4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= p_in;
      for (int j = 0; j < 3; j++) begin
        e1_1[j] <= $signed({p_in[1][j][COORD_BITS-1], p_in[1][j]})
                 - $signed({p_in[0][j][COORD_BITS-1], p_in[0][j]});
        e2_1[j] <= $signed({p_in[2][j][COORD_BITS-1], p_in[2][j]})
                 - $signed({p_in[0][j][COORD_BITS-1], p_in[0][j]});
        piv1[j] <= psum[j][COORD_BITS+1:2];
      end

      pr2[0] <= $signed(e1_1[1]) * $signed(e2_1[2]);
      pr2[1] <= $signed(e1_1[2]) * $signed(e2_1[1]);
      pr2[2] <= $signed(e1_1[2]) * $signed(e2_1[0]);
      pr2[3] <= $signed(e1_1[0]) * $signed(e2_1[2]);
      pr2[4] <= $signed(e1_1[0]) * $signed(e2_1[1]);
      pr2[5] <= $signed(e1_1[1]) * $signed(e2_1[0]);
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 3; j++) begin
          d2[i][j] <= $signed({p1[i][j][COORD_BITS-1], p1[i][j]})
                    - $signed({piv1[j][COORD_BITS-1], piv1[j]});
        end
      end
      piv2 <= piv1;

      for (int j = 0; j < 3; j++) begin
        neg3[j] <= k3[j][KW-1];
        mag3[j] <= k3[j][KW-1] ? nk3[j][MW-1:0] : k3[j][MW-1:0];
      end
      d3   <= d2;
      piv3 <= piv2;

      mag4  <= mag3;
      blen4 <= blen;
      dg4   <= 1'b0;
      neg4  <= neg3;
      d4    <= d3;
      piv4  <= piv3;

      for (int j = 0; j < 3; j++) begin
        m5[j] <= shv[j][MB-1:0];
      end
      dg5  <= (blen4 == '0);
      neg5 <= neg4;
      d5   <= d4;
      piv5 <= piv4;

      for (int j = 0; j < 3; j++) begin
        sq6[j] <= m5[j] * m5[j];
      end
      m6   <= m5;
      dg6  <= dg5 | dg4;
      neg6 <= neg5;
      d6   <= d5;
      piv6 <= piv5;

      sum7 <= {2'b00, sq6[0]} + {2'b00, sq6[1]} + {2'b00, sq6[2]};
      m7   <= m6;
      dg7  <= dg6;
      neg7 <= neg6;
      d7   <= d6;
      piv7 <= piv6;
    end
  end

  assign out_valid = v[7];
  assign d_out     = d7;
  assign piv_out   = piv7;
  assign neg_out   = neg7;
  assign degen_out = dg7;
  assign m_out     = m7;
  assign sum_out   = sum7;

endmodule

### hw/rtl/bqf_sqrt.sv
// ----------------------------------------------------------------------------
// bqf_sqrt
// Pipelined integer square root, one result bit per stage, with a side
// payload carried alongside.
// ----------------------------------------------------------------------------
module bqf_sqrt #(
  parameter int SW = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [bqf_pkg::SUM_BITS-1:0]      x,
  input  logic [SW-1:0]                     side,
  output logic                              out_valid,
  output logic [bqf_pkg::LEN_BITS-1:0]      len,
  output logic [SW-1:0]                     side_out
);

  localparam int N  = bqf_pkg::SQRT_STEPS;
  localparam int XW = bqf_pkg::SUM_BITS;

  logic [XW-1:0] x_r [N];
  logic [XW-1:0] r_r [N];
  logic [SW-1:0] s_r [N];
  logic          v_r [N];

  for (genvar s = 0; s < N; s++) begin : g_step
    logic [XW-1:0] xi, ri, trial;
    logic [SW-1:0] si;
    logic          vi;

    if (s == 0) begin : g_first
      assign xi = x;
      assign ri = '0;
      assign si = side;
      assign vi = in_valid;
    end else begin : g_next
      assign xi = x_r[s-1];
      assign ri = r_r[s-1];
      assign si = s_r[s-1];
      assign vi = v_r[s-1];
    end

    assign trial = ri + (XW'(1) << (XW - 2 - 2 * s));

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[s] <= si;
        if (xi >= trial) begin
          x_r[s] <= xi - trial;
          r_r[s] <= (ri >> 1) + (XW'(1) << (XW - 2 - 2 * s));
        end else begin
          x_r[s] <= xi;
          r_r[s] <= ri >> 1;
        end
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign len       = r_r[N-1][bqf_pkg::LEN_BITS-1:0];
  assign side_out  = s_r[N-1];

endmodule

### hw/rtl/bqf_div.sv
// ----------------------------------------------------------------------------
// bqf_div
// Three-lane pipelined restoring divider, one quotient bit per stage:
// n = round(m * 2^30 / len), signed by the cross product sign.
// ----------------------------------------------------------------------------
module bqf_div #(
  parameter int SW = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [2:0][bqf_pkg::MAN_BITS-1:0]     m,
  input  logic [bqf_pkg::LEN_BITS-1:0]          len,
  input  logic [2:0]                            neg,
  input  logic [SW-1:0]                         side,
  output logic                                  out_valid,
  output logic [2:0][bqf_pkg::NRM_BITS-1:0]     n,
  output logic [SW-1:0]                         side_out
);

  localparam int N  = bqf_pkg::QUO_BITS;
  localparam int RW = 64;
  localparam int DW = bqf_pkg::LEN_BITS + 1;
  localparam int MB = bqf_pkg::MAN_BITS;

  logic [2:0][RW-1:0] rem_r [N];
  logic [2:0][N-1:0]  q_r   [N];
  logic [DW-1:0]      den_r [N];
  logic [2:0]         neg_r [N];
  logic [SW-1:0]      s_r   [N];
  logic               v_r   [N];

  for (genvar s = 0; s < N; s++) begin : g_step
    localparam int B = N - 1 - s;
    logic [2:0][RW-1:0] remi, trial;
    logic [2:0][N-1:0]  qi;
    logic [DW-1:0]      deni;
    logic [2:0]         negi;
    logic [SW-1:0]      si;
    logic               vi;

    if (s == 0) begin : g_first
      // numerator (m << 31) + len, denominator 2 * len
      always_comb begin
        for (int j = 0; j < 3; j++) begin
          remi[j] = {{(RW-MB-N){1'b0}}, m[j], {N{1'b0}}}
                  + {{(RW-bqf_pkg::LEN_BITS){1'b0}}, len};
        end
      end
      assign qi   = '0;
      assign deni = {len, 1'b0};
      assign negi = neg;
      assign si   = side;
      assign vi   = in_valid;
    end else begin : g_next
      assign remi = rem_r[s-1];
      assign qi   = q_r[s-1];
      assign deni = den_r[s-1];
      assign negi = neg_r[s-1];
      assign si   = s_r[s-1];
      assign vi   = v_r[s-1];
    end

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        trial[j] = {{(RW-DW){1'b0}}, deni} << B;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s] <= deni;
        neg_r[s] <= negi;
        s_r[s]   <= si;
        for (int j = 0; j < 3; j++) begin
          if (remi[j] >= trial[j]) begin
            rem_r[s][j] <= remi[j] - trial[j];
            q_r[s][j]   <= qi[j] | (N'(1) << B);
          end else begin
            rem_r[s][j] <= remi[j];
            q_r[s][j]   <= qi[j];
          end
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      n[j] = neg_r[N-1][j] ? -{1'b0, q_r[N-1][j]} : {1'b0, q_r[N-1][j]};
    end
  end

  assign out_valid = v_r[N-1];
  assign side_out  = s_r[N-1];

endmodule

### hw/rtl/bqf_back.sv
// ----------------------------------------------------------------------------
// bqf_back
// Billboard axes from the normal, projection of the corner deltas and
// saturation of the offsets. Four register stages.
// ----------------------------------------------------------------------------
module bqf_back #(
  parameter int COORD_BITS = bqf_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic [2:0][bqf_pkg::NRM_BITS-1:0]       n,
  input  logic [3:0][2:0][COORD_BITS:0]           d,
  input  logic [2:0][COORD_BITS-1:0]              piv,
  input  logic                                    degen,
  output logic                                    out_valid,
  output logic [2:0][COORD_BITS-1:0]              piv_out,
  output logic [3:0][COORD_BITS-1:0]              u_out,
  output logic [3:0][COORD_BITS-1:0]              v_out,
  output logic                                    degen_out
);

  localparam int NW = bqf_pkg::NRM_BITS;
  localparam int AW = bqf_pkg::AXIS_BITS;
  localparam int EW = COORD_BITS + 1;
  localparam int XW = AW + EW;
  localparam int SW = XW + 2;
  localparam logic signed [SW-1:0] SMAX = {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = ~SMAX;

  logic [4:1] v;

  // stage a
  logic [3:0][2*NW-1:0]        nn;
  logic [NW-1:0]               na0, na2;
  logic [3:0][2:0][EW-1:0]     da, db, dc;
  logic [2:0][COORD_BITS-1:0]  piva, pivb, pivc;
  logic                        dga, dgb, dgc;
  // stage b
  logic [AW-1:0]               ax0, ax2, ay0, ay1, ay2;
  // stage c
  logic [3:0][1:0][XW-1:0]     pu;
  logic [3:0][2:0][XW-1:0]     pw;
  // stage d
  logic signed [SW-1:0]        su [4];
  logic signed [SW-1:0]        sv [4];
  logic signed [SW-1:0]        hu [4];
  logic signed [SW-1:0]        hv [4];
  logic [3:0][COORD_BITS-1:0]  uo, vo;
  logic [2:0][COORD_BITS-1:0]  pivd;
  logic                        dgd;

  function automatic logic [AW-1:0] rnd30(input logic signed [2*NW+1:0] x);
    logic signed [2*NW+1:0] t;
    t = x + (2*NW+2)'(64'd1 << (bqf_pkg::ONE_SHIFT - 1));
    return t[bqf_pkg::ONE_SHIFT+AW-1:bqf_pkg::ONE_SHIFT];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:1], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      su[i] = $signed({{2{pu[i][0][XW-1]}}, pu[i][0]})
            + $signed({{2{pu[i][1][XW-1]}}, pu[i][1]});
      sv[i] = $signed({{2{pw[i][0][XW-1]}}, pw[i][0]})
            + $signed({{2{pw[i][1][XW-1]}}, pw[i][1]})
            + $signed({{2{pw[i][2][XW-1]}}, pw[i][2]});
      hu[i] = su[i] >>> bqf_pkg::ONE_SHIFT;
      hv[i] = sv[i] >>> bqf_pkg::ONE_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nn[0] <= $signed(n[0]) * $signed(n[1]);
      nn[1] <= $signed(n[0]) * $signed(n[0]);
      nn[2] <= $signed(n[2]) * $signed(n[2]);
      nn[3] <= $signed(n[1]) * $signed(n[2]);
      na0   <= n[0];
      na2   <= n[2];
      da    <= d;
      piva  <= piv;
      dga   <= degen;

      // x axis = (nz, 0, -nx), y axis = (-nx*ny, nx*nx + nz*nz, -ny*nz)
      ax0  <= {na2[NW-1], na2};
      ax2  <= -{na0[NW-1], na0};
      ay0  <= rnd30(-$signed({{2{nn[0][2*NW-1]}}, nn[0]}));
      ay1  <= rnd30($signed({{2{nn[1][2*NW-1]}}, nn[1]})
                  + $signed({{2{nn[2][2*NW-1]}}, nn[2]}));
      ay2  <= rnd30(-$signed({{2{nn[3][2*NW-1]}}, nn[3]}));
      db   <= da;
      pivb <= piva;
      dgb  <= dga;

      for (int i = 0; i < 4; i++) begin
        pu[i][0] <= $signed(ax0) * $signed(db[i][0]);
        pu[i][1] <= $signed(ax2) * $signed(db[i][2]);
        pw[i][0] <= $signed(ay0) * $signed(db[i][0]);
        pw[i][1] <= $signed(ay1) * $signed(db[i][1]);
        pw[i][2] <= $signed(ay2) * $signed(db[i][2]);
      end
      dc   <= db;
      pivc <= pivb;
      dgc  <= dgb;

      for (int i = 0; i < 4; i++) begin
        if (dgc) begin
          uo[i] <= '0;
          vo[i] <= '0;
        end else begin
          uo[i] <= (hu[i] > SMAX) ? SMAX[COORD_BITS-1:0] :
                   (hu[i] < SMIN) ? SMIN[COORD_BITS-1:0] : hu[i][COORD_BITS-1:0];
          vo[i] <= (hv[i] > SMAX) ? SMAX[COORD_BITS-1:0] :
                   (hv[i] < SMIN) ? SMIN[COORD_BITS-1:0] : hv[i][COORD_BITS-1:0];
        end
      end
      pivd <= pivc;
      dgd  <= dgc;
    end
  end

  assign out_valid = v[4];
  assign piv_out   = pivd;
  assign u_out     = uo;
  assign v_out     = vo;
  assign degen_out = dgd;

endmodule
